// ===== rtl/iol_pkg.sv =====
package iol_pkg;

    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;
    localparam int COUNT_W = 7;

    localparam logic [OP_W-1:0] OP_READ     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_POS  = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_in_word;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [ST_W-1:0]         status;
        logic [COUNT_W-1:0]      entry_count;
    } t_out_word;

    // per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

// ===== rtl/indexed_ordered_list.sv =====
// result: each accepted word gives a registered result word in the next cycle
// throughput: one word per cycle while the output is not stalled; every cell of the row shifts in parallel,
// so an insert or delete at any position finishes in a single update
// reset: synchronous, active low; clears the entry count and the output valid,
// element cells are not cleared and hold no meaning until written
module indexed_ordered_list #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  iol_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output iol_pkg::t_out_word o_out_word
);
    import iol_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_out_valid;
    t_out_word       r_out;
    t_out_word       n_out;

    logic            accept;
    logic            full;
    logic            do_ins;
    logic            do_del;
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic [CMPW-1:0] tgt;
    t_cell_ctl       ctl;

    logic signed [VAL_W-1:0] values [CAPACITY];
    logic signed [VAL_W-1:0] taps   [CAPACITY];
    logic signed [VAL_W-1:0] tap_or;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign pos_x = CMPW'(i_in_word.position);
    assign cnt_x = CMPW'(r_count);
    assign full  = (r_count == CW'(CAPACITY));

    always_comb begin
        tap_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            tap_or = tap_or | taps[k];
        end
    end

    always_comb begin
        do_ins            = 1'b0;
        do_del            = 1'b0;
        tgt               = pos_x;
        n_count           = r_count;
        n_out.read_value  = '0;
        n_out.status      = ST_DONE;
        case (i_in_word.op)
            OP_READ: begin
                if (pos_x >= cnt_x) begin
                    n_out.read_value = '1;
                    n_out.status     = ST_RANGE;
                end else begin
                    n_out.read_value = tap_or;
                end
            end
            OP_INS_HEAD: begin
                tgt = '0;
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_INS_TAIL: begin
                tgt = cnt_x;
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_INS_POS: begin
                // range check wins over the full check
                if (pos_x > cnt_x) begin
                    n_out.status = ST_RANGE;
                end else if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_DELETE: begin
                if (pos_x >= cnt_x) begin
                    n_out.status = ST_RANGE;
                end else begin
                    do_del = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_del) begin
            n_count = r_count - CW'(1);
        end
        n_out.entry_count = COUNT_W'(n_count);
    end

    assign ctl.ins   = do_ins & accept;
    assign ctl.del   = do_del & accept;
    assign ctl.value = i_in_word.item_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] left_v;
        logic signed [VAL_W-1:0] right_v;

        if (g == 0) begin : g_head
            assign left_v = i_in_word.item_value;
        end else begin : g_mid_l
            assign left_v = values[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign right_v = values[g];
        end else begin : g_mid_r
            assign right_v = values[g+1];
        end

        iol_cell #(
            .INDEX (g),
            .PW    (CMPW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_pos   (tgt),
            .i_left  (left_v),
            .i_right (right_v),
            .o_value (values[g]),
            .o_tap   (taps[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== rtl/iol_cell.sv =====
module iol_cell #(
    parameter int INDEX = 0,
    parameter int PW    = 7
) (
    input  logic                            i_clk,
    input  iol_pkg::t_cell_ctl              i_ctl,
    input  logic [PW-1:0]                   i_pos,
    input  logic signed [iol_pkg::VAL_W-1:0] i_left,
    input  logic signed [iol_pkg::VAL_W-1:0] i_right,
    output logic signed [iol_pkg::VAL_W-1:0] o_value,
    output logic signed [iol_pkg::VAL_W-1:0] o_tap
);
    import iol_pkg::*;

    localparam logic [PW-1:0] Idx = PW'(INDEX);

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            // cells past the gap take their left neighbor
            if (Idx > i_pos) begin
                n_value = i_left;
            end else if (Idx == i_pos) begin
                n_value = i_ctl.value;
            end
        end else if (i_ctl.del) begin
            if (Idx >= i_pos) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_tap   = (Idx == i_pos) ? r_value : '0;

endmodule

// ===== sim/tb_indexed_ordered_list.sv =====
`timescale 1ns / 100ps

module tb_indexed_ordered_list;

    import iol_pkg::*;

    localparam int LIST_CAP    = 64;
    localparam int N_RANDOM    = 850;
    localparam int IDLE_LIMIT  = 1000;
    localparam int TAIL_CYCLES = 10;

    typedef struct {
        t_in_word word;
        bit       drain;
    } t_pending_op;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;

    t_pending_op op_queue[$];
    t_out_word   pending_results[$];

    // list contents as the block should hold them
    logic signed [VAL_W-1:0] shadow_list [LIST_CAP];
    int shadow_cnt  = 0;

    int gen_cnt     = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int tx_calm     = 0;
    int rx_calm     = 0;
    int sent_cnt    = 0;
    int checked_cnt = 0;
    int err_cnt     = 0;
    int idle_cycles = 0;

    indexed_ordered_list #(
        .CAPACITY (LIST_CAP)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always #1 clk = ~clk;

    function automatic t_out_word list_apply(input t_in_word w);
        t_out_word r;
        logic      full;
        int        at;
        r    = '0;
        full = shadow_cnt >= LIST_CAP;
        at   = -1;
        case (w.op)
            OP_READ: begin
                if (int'(w.position) >= shadow_cnt) begin
                    r.read_value = -1;
                    r.status     = ST_RANGE;
                end else begin
                    r.read_value = shadow_list[w.position[$clog2(LIST_CAP)-1:0]];
                end
            end
            OP_INS_HEAD: begin
                if (full) r.status = ST_FULL;
                else at = 0;
            end
            OP_INS_TAIL: begin
                if (full) r.status = ST_FULL;
                else at = shadow_cnt;
            end
            OP_INS_POS: begin
                // range is checked ahead of full
                if (int'(w.position) > shadow_cnt) r.status = ST_RANGE;
                else if (full) r.status = ST_FULL;
                else at = int'(w.position);
            end
            OP_DELETE: begin
                if (int'(w.position) >= shadow_cnt) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int i = int'(w.position); i < shadow_cnt - 1; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_cnt--;
                end
            end
            default: ;
        endcase
        if (at >= 0) begin
            for (int i = shadow_cnt; i > at; i--)
                shadow_list[i] = shadow_list[i - 1];
            shadow_list[at] = w.item_value;
            shadow_cnt++;
        end
        r.entry_count = shadow_cnt[COUNT_W-1:0];
        return r;
    endfunction

    function automatic int draw_idle(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // mostly a legal position up to hi, now and then the first bad one or anything
    function automatic int pick_pos(input int hi);
        int p;
        p = $urandom_range(0, 19);
        if (p == 0) return $urandom_range(0, 127);
        if (p == 1 || hi < 0) return hi + 1;
        return $urandom_range(0, hi);
    endfunction

    task automatic add_item(input logic [OP_W-1:0] op, input int pos,
                            input logic [VAL_W-1:0] value, input bit drain);
        t_pending_op p;
        p.word.op         = op;
        p.word.position   = pos[POS_W-1:0];
        p.word.item_value = value;
        p.drain           = drain;
        op_queue.push_back(p);
        // track only the length so positions can be aimed at the live list
        case (op)
            OP_INS_HEAD, OP_INS_TAIL: if (gen_cnt < LIST_CAP) gen_cnt++;
            OP_INS_POS: if (pos <= gen_cnt && gen_cnt < LIST_CAP) gen_cnt++;
            OP_DELETE: if (pos < gen_cnt) gen_cnt--;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        if (err_cnt < 200) $display("mismatch at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    always @(posedge clk) begin : driver
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) sent_cnt++;
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (op_queue.size() > 0 &&
                         (!op_queue[0].drain || sent_cnt == checked_cnt)) begin
                in_word  <= op_queue[0].word;
                in_valid <= 1'b1;
                void'(op_queue.pop_front());
                gap_left = draw_idle(tx_calm);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : monitor
        t_out_word want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (in_valid && !in_stall) pending_results.push_back(list_apply(in_word));
            if (out_valid && !out_stall) begin
                checked_cnt <= checked_cnt + 1;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result word %0d with nothing expected",
                                              checked_cnt));
                end else begin
                    want = pending_results.pop_front();
                    if (out_word.read_value !== want.read_value)
                        report_mismatch($sformatf("word %0d read_value got %0d want %0d",
                            checked_cnt, out_word.read_value, want.read_value));
                    if (out_word.status !== want.status)
                        report_mismatch($sformatf("word %0d status got %0d want %0d",
                            checked_cnt, out_word.status, want.status));
                    if (out_word.entry_count !== want.entry_count)
                        report_mismatch($sformatf("word %0d entry_count got %0d want %0d",
                            checked_cnt, out_word.entry_count, want.entry_count));
                end
                stall_left = draw_idle(rx_calm);
            end else if (out_valid && stall_left > 0) begin
                stall_left--;
            end
            out_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int  goal;
        int  hold_left;
        int  r;
        int  grow_pct;
        int  n_random;
        bit  first;

        // empty list: every position is out of range
        add_item(OP_READ,    0,   pick_value(), 1'b0);
        add_item(OP_DELETE,  0,   pick_value(), 1'b0);
        add_item(OP_INS_POS, 1,   32'h1234_5678, 1'b0);
        add_item(OP_INS_POS, 127, 32'h1234_5678, 1'b0);
        // unused codes do nothing
        add_item(3'd5, 127, 32'hffff_ffff, 1'b0);
        add_item(3'd6, 0,   32'h0000_0000, 1'b0);
        add_item(3'd7, 127, 32'hffff_ffff, 1'b0);
        // every insert kind, extreme values
        add_item(OP_INS_HEAD, 127, 32'h7fff_ffff, 1'b0);
        add_item(OP_INS_TAIL, 127, 32'h8000_0000, 1'b0);
        add_item(OP_INS_POS,  1,   32'hffff_ffff, 1'b0);
        add_item(OP_INS_POS,  3,   32'h0000_0000, 1'b0);
        add_item(OP_INS_POS,  0,   32'h5555_5555, 1'b0);
        for (int i = 0; i < 5; i++) add_item(OP_READ, i, 32'hffff_ffff, 1'b0);
        add_item(OP_READ, 5,   32'h0, 1'b0);
        add_item(OP_READ, 127, 32'h0, 1'b0);
        // delete at tail, head and middle
        add_item(OP_DELETE, 4,   32'h0, 1'b0);
        add_item(OP_DELETE, 0,   32'h0, 1'b0);
        add_item(OP_DELETE, 1,   32'h0, 1'b0);
        add_item(OP_READ,   0,   32'h0, 1'b0);
        add_item(OP_READ,   1,   32'h0, 1'b0);
        add_item(OP_DELETE, 127, 32'h0, 1'b0);

        // random part walks the length toward a goal: empty, full or in between
        goal      = LIST_CAP;
        hold_left = $urandom_range(4, 24);
        first     = 1'b1;
        n_random  = 0;
        while (n_random < N_RANDOM) begin
            if (gen_cnt == goal && hold_left > 0) begin
                hold_left--;
            end else if (gen_cnt == goal) begin
                r         = $urandom_range(0, 2);
                goal      = (r == 0) ? 0 : (r == 1) ? LIST_CAP : $urandom_range(1, LIST_CAP - 1);
                hold_left = $urandom_range(4, 24);
            end
            if (gen_cnt < goal) grow_pct = 80;
            else if (gen_cnt > goal) grow_pct = 20;
            else if (goal == LIST_CAP) grow_pct = 70;
            else if (goal == 0) grow_pct = 30;
            else grow_pct = 50;

            r = $urandom_range(0, 99);
            if (r < 5) begin
                add_item(OP_W'($urandom_range(0, 7)), $urandom_range(0, 127), $urandom(),
                         first);
            end else if (r < 30) begin
                add_item(OP_READ, pick_pos(gen_cnt - 1), pick_value(), first);
            end else if ($urandom_range(0, 99) < grow_pct) begin
                case ($urandom_range(0, 2))
                    0: add_item(OP_INS_HEAD, $urandom_range(0, 127), pick_value(), first);
                    1: add_item(OP_INS_TAIL, $urandom_range(0, 127), pick_value(), first);
                    default: add_item(OP_INS_POS, pick_pos(gen_cnt), pick_value(), first);
                endcase
            end else begin
                add_item(OP_DELETE, pick_pos(gen_cnt - 1), pick_value(), first);
            end
            n_random++;
            // hold the sender now and then until the result side has caught up
            first = ($urandom_range(0, 149) == 0);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do @(negedge clk);
        while (op_queue.size() != 0 || in_valid || pending_results.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
